// File: src/msuo_pkg.sv
// Package for the multi-stage unit occupancy tracker.
// Holds sizes, register and mode codes, shared structs and the stage cycle lookup.
// No dependencies; every other file of the block imports it.
package msuo_pkg;

    // Default sizes handed to the top level parameters
    localparam int DEF_MAX_UNITS   = 4;
    localparam int DEF_MAX_STAGES  = 4;
    localparam int DEF_INSTR_WIDTH = 32;

    // Beat payload widths
    localparam int WORD_W = 32;

    // Configuration register file
    localparam int DATA_W        = 32;
    localparam int CFG_ADDR_W    = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int UNITS_W       = 3;
    localparam int NUM_UNIT_REGS = 4;
    localparam int UREG_W        = $clog2(NUM_UNIT_REGS);
    localparam int CYC_W         = 8;
    localparam int BYTES_PER_REG = DATA_W / CYC_W;

    localparam logic [CFG_IDX_W-1:0] REG_UNITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT3 = 3'd4;

    localparam logic [UNITS_W-1:0] UNITS_RESET = 3'd1;
    localparam logic [DATA_W-1:0]  CYCLES_RESET = 32'd1;

    // Item modes
    localparam logic MODE_ISSUE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [UNITS_W-1:0]                   units_in_use;
        logic [NUM_UNIT_REGS-1:0][DATA_W-1:0] unit_cycles;
    } msuo_cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted input beat
        logic commit;    // update unit state and load the result register
    } msuo_cmd_t;

    // Cycle count of stage s of unit u; zero where no register byte exists
    function automatic logic [CYC_W-1:0] stage_cycles(msuo_cfg_t c, int u, int s);
        logic [DATA_W-1:0] r;
        r = '0;
        if (u < NUM_UNIT_REGS && s < BYTES_PER_REG)
        begin
            r = c.unit_cycles[u[UREG_W-1:0]];
            return r[s*CYC_W +: CYC_W];
        end
        return '0;
    endfunction

endpackage

// File: src/msuo_in_if.sv
// Input channel of the occupancy tracker: valid/ready plus the item payload.
// Depends on msuo_pkg.
interface msuo_in_if;
    import msuo_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [WORD_W-1:0] instr_word;

    modport source (output valid, output mode, output instr_word, input ready);
    modport sink   (input valid, input mode, input instr_word, output ready);
endinterface

// File: src/msuo_out_if.sv
// Result channel of the occupancy tracker: valid/ready plus the result payload.
// Depends on msuo_pkg.
interface msuo_out_if;
    import msuo_pkg::*;

    logic              valid;
    logic              ready;
    logic              issue_ok;
    logic              stall_res;
    logic              wb_written;
    logic [WORD_W-1:0] wb_instr;
    logic              all_idle;

    modport source (output valid, output issue_ok, output stall_res, output wb_written,
                    output wb_instr, output all_idle, input ready);
    modport sink   (input valid, input issue_ok, input stall_res, input wb_written,
                    input wb_instr, input all_idle, output ready);
endinterface

// File: src/multi_stage_unit_occupancy.sv
// Top level of the multi-stage unit occupancy tracker.
// Depends on msuo_pkg, msuo_in_if, msuo_out_if, msuo_cfg, msuo_ctrl and msuo_dp.
//
//   channel  dir  handshake       payload
//   item     in   valid/ready     mode, instr_word
//   result   out  valid/ready     issue_ok, stall_res, wb_written, wb_instr, all_idle
//   apb      in   psel/penable    paddr, pwdata, prdata (pready tied high)
//
// Each item is first captured from the input beat; then, in the execute state,
// all stages of all units update together and the result register loads.
// The result register sits between the sides: the next item is taken while a
// result beat still waits; a stalled result holds the item in its execute state.
// Reset (rst_n low, asynchronous) frees every stage and clears writeback.
module multi_stage_unit_occupancy #(
    parameter int MAX_UNITS   = msuo_pkg::DEF_MAX_UNITS,
    parameter int MAX_STAGES  = msuo_pkg::DEF_MAX_STAGES,
    parameter int INSTR_WIDTH = msuo_pkg::DEF_INSTR_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    msuo_in_if.sink                         item,
    msuo_out_if.source                      result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [msuo_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [msuo_pkg::DATA_W-1:0]     pwdata,
    output logic [msuo_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import msuo_pkg::*;

    msuo_cfg_t cfg;
    msuo_cmd_t cmd;

    msuo_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msuo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    msuo_dp #(
        .MAX_UNITS   (MAX_UNITS),
        .MAX_STAGES  (MAX_STAGES),
        .INSTR_WIDTH (INSTR_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .mode       (item.mode),
        .instr_word (item.instr_word),
        .issue_ok   (result.issue_ok),
        .stall_res  (result.stall_res),
        .wb_written (result.wb_written),
        .wb_instr   (result.wb_instr),
        .all_idle   (result.all_idle)
    );

endmodule

// File: src/msuo_cfg.sv
// APB-style configuration registers: unit count and per-unit stage cycle counts.
// Depends on msuo_pkg.
module msuo_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [msuo_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [msuo_pkg::DATA_W-1:0]        pwdata,
    output logic [msuo_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    output msuo_pkg::msuo_cfg_t                cfg
);
    import msuo_pkg::*;

    logic [UNITS_W-1:0]                   units_reg;
    logic [NUM_UNIT_REGS-1:0][DATA_W-1:0] cycles_reg;
    logic [CFG_IDX_W-1:0]                 idx;
    logic [UREG_W-1:0]                    ureg;
    logic                                 wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign ureg   = UREG_W'(idx - REG_UNIT0);
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_reg  <= UNITS_RESET;
            cycles_reg <= {NUM_UNIT_REGS{CYCLES_RESET}};
        end
        else if (wr_en)
        begin
            unique case (idx) inside
                REG_UNITS:
                begin
                    units_reg <= pwdata[UNITS_W-1:0];
                end
                REG_UNIT0, REG_UNIT1, REG_UNIT2, REG_UNIT3:
                begin
                    cycles_reg[ureg] <= pwdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        unique case (idx) inside
            REG_UNITS:                              prdata = DATA_W'(units_reg);
            REG_UNIT0, REG_UNIT1, REG_UNIT2, REG_UNIT3: prdata = cycles_reg[ureg];
            default:                                prdata = '0;
        endcase
    end

    assign cfg.units_in_use = units_reg;
    assign cfg.unit_cycles  = cycles_reg;

endmodule

// File: src/msuo_ctrl.sv
// Controller of the occupancy tracker: input capture, execute, result register valid.
// Depends on msuo_pkg; drives commands into msuo_dp.
module msuo_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output msuo_pkg::msuo_cmd_t  cmd
);
    import msuo_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // commit only when the result register can take the beat
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/msuo_dp.sv
// Datapath of the occupancy tracker: stage busy bits, countdowns, words,
// writeback register, issue search, tick walk and result register.
// Depends on msuo_pkg; commanded by msuo_ctrl.
module msuo_dp #(
    parameter int MAX_UNITS   = msuo_pkg::DEF_MAX_UNITS,
    parameter int MAX_STAGES  = msuo_pkg::DEF_MAX_STAGES,
    parameter int INSTR_WIDTH = msuo_pkg::DEF_INSTR_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  msuo_pkg::msuo_cmd_t           cmd,
    input  msuo_pkg::msuo_cfg_t           cfg,
    input  logic                          mode,
    input  logic [msuo_pkg::WORD_W-1:0]   instr_word,
    output logic                          issue_ok,
    output logic                          stall_res,
    output logic                          wb_written,
    output logic [msuo_pkg::WORD_W-1:0]   wb_instr,
    output logic                          all_idle
);
    import msuo_pkg::*;

    // held input beat
    logic                   mode_reg;
    logic [INSTR_WIDTH-1:0] word_in_reg;
    logic [63:0]            word_in_wide;

    // unit state
    logic                   busy_reg  [MAX_UNITS][MAX_STAGES];
    logic                   busy_next [MAX_UNITS][MAX_STAGES];
    logic [CYC_W-1:0]       cd_reg    [MAX_UNITS][MAX_STAGES];
    logic [CYC_W-1:0]       cd_next   [MAX_UNITS][MAX_STAGES];
    logic [INSTR_WIDTH-1:0] word_reg  [MAX_UNITS][MAX_STAGES];
    logic [INSTR_WIDTH-1:0] word_next [MAX_UNITS][MAX_STAGES];
    logic [INSTR_WIDTH-1:0] wb_reg, wb_next;
    logic [63:0]            wb_wide;

    // walk helpers; the extra slot past the last stage stands for "no stage"
    logic pres     [MAX_UNITS][MAX_STAGES+1];
    logic last     [MAX_UNITS][MAX_STAGES];
    logic after    [MAX_UNITS][MAX_STAGES+1];
    logic moved_in [MAX_UNITS][MAX_STAGES+1];
    logic retire   [MAX_UNITS][MAX_STAGES];

    // result register
    logic issue_ok_reg, issue_ok_next;
    logic stall_reg, stall_next;
    logic wrote_reg, wrote_next;
    logic idle_reg, idle_next;

    assign word_in_wide = 64'(instr_word);

    // capture the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg    <= mode;
            word_in_reg <= word_in_wide[INSTR_WIDTH-1:0];
        end
    end

    // present stages: unit within the count and an unbroken run of nonzero cycle bytes
    always_comb
    begin
        logic run;
        run = 1'b0;
        for (int u = 0; u < MAX_UNITS; u++)
        begin
            run = (u < int'(cfg.units_in_use));
            for (int s = 0; s < MAX_STAGES; s++)
            begin
                run = run && (stage_cycles(cfg, u, s) != '0);
                pres[u][s] = run;
            end
            pres[u][MAX_STAGES] = 1'b0;
            for (int s = 0; s < MAX_STAGES; s++)
            begin
                last[u][s] = pres[u][s] && !pres[u][s+1];
            end
        end
    end

    // tick walk: last stage to first, a stage sees the next one after its own update
    always_comb
    begin
        for (int u = 0; u < MAX_UNITS; u++)
        begin
            after[u][MAX_STAGES]    = 1'b1;
            moved_in[u][MAX_STAGES] = 1'b0;
            for (int s = MAX_STAGES - 1; s >= 0; s--)
            begin
                after[u][s]    = busy_reg[u][s];
                moved_in[u][s] = 1'b0;
                retire[u][s]   = 1'b0;
            end
            for (int s = MAX_STAGES - 1; s >= 0; s--)
            begin
                if (pres[u][s] && busy_reg[u][s] && (cd_reg[u][s] == '0)
                    && (last[u][s] || !after[u][s+1]))
                begin
                    after[u][s] = 1'b0;
                    if (last[u][s])
                    begin
                        retire[u][s] = 1'b1;
                    end
                    else
                    begin
                        moved_in[u][s+1] = 1'b1;
                    end
                end
            end
        end
    end

    // next unit state and result fields
    always_comb
    begin
        logic found;
        logic any_busy;
        found         = 1'b0;
        any_busy      = 1'b0;
        busy_next     = busy_reg;
        cd_next       = cd_reg;
        word_next     = word_reg;
        wb_next       = wb_reg;
        issue_ok_next = 1'b0;
        stall_next    = 1'b0;
        wrote_next    = 1'b0;

        if (mode_reg == MODE_TICK)
        begin
            for (int u = 0; u < MAX_UNITS; u++)
            begin
                for (int s = 0; s < MAX_STAGES; s++)
                begin
                    busy_next[u][s] = after[u][s] || moved_in[u][s];
                    if (moved_in[u][s])
                    begin
                        cd_next[u][s] = CYC_W'(stage_cycles(cfg, u, s) - 1'b1);
                    end
                    else if (pres[u][s] && busy_reg[u][s] && (cd_reg[u][s] != '0))
                    begin
                        cd_next[u][s] = CYC_W'(cd_reg[u][s] - 1'b1);
                    end
                    // higher units come later, so the last retiring unit wins
                    if (retire[u][s])
                    begin
                        wb_next    = word_reg[u][s];
                        wrote_next = 1'b1;
                    end
                end
                for (int s = 1; s < MAX_STAGES; s++)
                begin
                    if (moved_in[u][s])
                    begin
                        word_next[u][s] = word_reg[u][s-1];
                    end
                end
            end
        end
        else
        begin
            // issue into the first present unit with a free first stage
            for (int u = 0; u < MAX_UNITS; u++)
            begin
                if (!found && pres[u][0] && !busy_reg[u][0])
                begin
                    found           = 1'b1;
                    busy_next[u][0] = 1'b1;
                    cd_next[u][0]   = CYC_W'(stage_cycles(cfg, u, 0) - 1'b1);
                    word_next[u][0] = word_in_reg;
                end
            end
            issue_ok_next = found;
            stall_next    = !found;
        end

        // idle check over present stages only
        for (int u = 0; u < MAX_UNITS; u++)
        begin
            for (int s = 0; s < MAX_STAGES; s++)
            begin
                if (pres[u][s] && busy_next[u][s])
                begin
                    any_busy = 1'b1;
                end
            end
        end
        idle_next = !any_busy;
    end

    // control-side state: busy bits, countdowns, writeback
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int u = 0; u < MAX_UNITS; u++)
            begin
                for (int s = 0; s < MAX_STAGES; s++)
                begin
                    busy_reg[u][s] <= 1'b0;
                    cd_reg[u][s]   <= '0;
                end
            end
            wb_reg <= '0;
        end
        else if (cmd.commit)
        begin
            busy_reg <= busy_next;
            cd_reg   <= cd_next;
            wb_reg   <= wb_next;
        end
    end

    // stage words and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            word_reg     <= word_next;
            issue_ok_reg <= issue_ok_next;
            stall_reg    <= stall_next;
            wrote_reg    <= wrote_next;
            idle_reg     <= idle_next;
        end
    end

    assign wb_wide    = 64'(wb_reg);
    assign issue_ok   = issue_ok_reg;
    assign stall_res  = stall_reg;
    assign wb_written = wrote_reg;
    assign wb_instr   = wb_wide[WORD_W-1:0];
    assign all_idle   = idle_reg;

endmodule
